### sv/qrs_pkg.sv
// Shared constants and beat types of the quadratic root solver.
`default_nettype none

package qrs_pkg;

  // Fixed-point format of every coefficient and every root.
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Solution cases reported with each result beat.
  typedef enum logic [2:0] {
    KIND_TWO_REAL = 3'd0,
    KIND_DOUBLE   = 3'd1,
    KIND_COMPLEX  = 3'd2,
    KIND_LINEAR   = 3'd3,
    KIND_NONE     = 3'd4,
    KIND_INFINITE = 3'd5
  } kind_e;

  // One coefficient set.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;
  } in_beat_t;

  // One solution.
  typedef struct packed {
    kind_e                        root_kind;
    logic signed [DATA_WIDTH-1:0] first_root;
    logic signed [DATA_WIDTH-1:0] second_root;
    logic signed [DATA_WIDTH-1:0] imag_part;
    logic                         overflow;
  } out_beat_t;

endpackage

`default_nettype wire

### sv/quadratic_root_solver_top.sv
// Pipelined quadratic root solver: products, discriminant, square root, dividers.
//
//   Channel | Direction | Handshake               | Beat
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o | coef_a, coef_b, coef_c
//   out     | output    | out_valid_o/out_stall_i | kind, two roots, imag, ovf
//
// One coefficient set enters per cycle unless in_stall_o is high; each result is offered
// once its coefficients have passed 89 registers (at Q16.16), a depth set by
// the one-bit-per-stage square root and the one-bit-per-stage restoring dividers.
// All stages move together whenever the output register is empty or being taken,
// so a stall on the output holds every stage and raises in_stall_o in the same cycle.
// Reset clears only the valid bits of the stages and of the output register.
`default_nettype none

module quadratic_root_solver_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire qrs_pkg::in_beat_t in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output qrs_pkg::out_beat_t     out_beat_o
);

  localparam int unsigned W      = qrs_pkg::DATA_WIDTH;
  localparam int unsigned F      = qrs_pkg::FRAC_BITS;
  localparam int unsigned LO_W   = W / 2;
  localparam int unsigned HI_W   = W - LO_W;
  localparam int unsigned PW     = 2 * W;
  localparam int unsigned DISC_W = 2 * W + 1;
  localparam int unsigned ROOT_W = W + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned SREM_W = ROOT_W + 2;
  localparam int unsigned NUM_W  = W + 2;
  localparam int unsigned QUO_W  = NUM_W + F;
  localparam int unsigned DIV_W  = W + 1;

  typedef struct packed {
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
  } coef_t;

  typedef struct packed {
    coef_t                coef;
    qrs_pkg::kind_e       kind;
    logic [RAD_W-1:0]     rad;
    logic [SREM_W-1:0]    rem;
    logic [ROOT_W-1:0]    root;
  } sq_t;

  typedef struct packed {
    logic [QUO_W-1:0] nq;
    logic [DIV_W-1:0] rem;
    logic             neg;
  } lane_t;

  typedef struct packed {
    qrs_pkg::kind_e   kind;
    logic [DIV_W-1:0] dvsr;
    lane_t [2:0]      lane;
  } dv_t;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [NUM_W-1:0] abs_num(input logic signed [NUM_W:0] v);
    logic [NUM_W:0] u;
    u = v[NUM_W] ? (~v + 1'b1) : v;
    return u[NUM_W-1:0];
  endfunction

  // Whole pipeline steps when the output register can take a beat.
  logic adv;
  assign adv        = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~adv;

  // Stage A: split into sign and magnitude.
  logic  a_vld_q;
  coef_t a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q.an <= in_beat_i.coef_a[W-1];
      a_q.bn <= in_beat_i.coef_b[W-1];
      a_q.cn <= in_beat_i.coef_c[W-1];
      a_q.am <= mag_of(in_beat_i.coef_a);
      a_q.bm <= mag_of(in_beat_i.coef_b);
      a_q.cm <= mag_of(in_beat_i.coef_c);
    end
  end

  // Stage B: half-width partial products of b*b and a*c.
  logic                 b_vld_q;
  coef_t                b_q;
  logic [W+LO_W-1:0]    pbl_q, pal_q;
  logic [W+HI_W-1:0]    pbh_q, pah_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_q   <= a_q;
      pbl_q <= (W+LO_W)'(a_q.bm) * (W+LO_W)'(a_q.bm[LO_W-1:0]);
      pbh_q <= (W+HI_W)'(a_q.bm) * (W+HI_W)'(a_q.bm[W-1:LO_W]);
      pal_q <= (W+LO_W)'(a_q.am) * (W+LO_W)'(a_q.cm[LO_W-1:0]);
      pah_q <= (W+HI_W)'(a_q.am) * (W+HI_W)'(a_q.cm[W-1:LO_W]);
    end
  end

  // Stage C: full products.
  logic          c_vld_q;
  coef_t         c_q;
  logic [PW-1:0] bb_q, ac_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q  <= b_q;
      bb_q <= PW'(pbl_q) + (PW'(pbh_q) << LO_W);
      ac_q <= PW'(pal_q) + (PW'(pah_q) << LO_W);
    end
  end

  // Stage D: discriminant and case; it loads the first square root slot.
  logic             sq_vld_q [0:ROOT_W];
  sq_t              sq_q     [0:ROOT_W];
  logic [DISC_W-1:0] bbx, ac4, dmag;
  logic              same_sign;
  qrs_pkg::kind_e    kind_d;
  always_comb begin
    bbx       = DISC_W'(bb_q);
    ac4       = DISC_W'({ac_q, 2'b00});
    same_sign = (c_q.an == c_q.cn);
    if (!same_sign) begin
      dmag = bbx + ac4;
    end else if (bbx >= ac4) begin
      dmag = bbx - ac4;
    end else begin
      dmag = ac4 - bbx;
    end
    if (c_q.am != '0) begin
      if (dmag == '0) begin
        kind_d = qrs_pkg::KIND_DOUBLE;
      end else if (!same_sign || (bbx > ac4)) begin
        kind_d = qrs_pkg::KIND_TWO_REAL;
      end else begin
        kind_d = qrs_pkg::KIND_COMPLEX;
      end
    end else if (c_q.bm != '0) begin
      kind_d = qrs_pkg::KIND_LINEAR;
    end else if (c_q.cm != '0) begin
      kind_d = qrs_pkg::KIND_NONE;
    end else begin
      kind_d = qrs_pkg::KIND_INFINITE;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= c_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].coef <= c_q;
      sq_q[0].kind <= kind_d;
      sq_q[0].rad  <= RAD_W'(dmag);
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
    end
  end

  // Square root: one result bit per stage, two radicand bits consumed.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [SREM_W-1:0] rem_sh, trial;
    sq_t               nxt;
    always_comb begin
      rem_sh = {sq_q[i].rem[SREM_W-3:0], sq_q[i].rad[RAD_W-1:RAD_W-2]};
      trial  = {sq_q[i].root, 2'b01};
      nxt    = sq_q[i];
      nxt.rad = {sq_q[i].rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        nxt.rem  = rem_sh - trial;
        nxt.root = {sq_q[i].root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem_sh;
        nxt.root = {sq_q[i].root[ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[i+1] <= sq_vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[i+1] <= nxt;
      end
    end
  end

  // Stage E: numerators, divisor and quotient signs for the three lanes.
  logic             dv_vld_q [0:QUO_W];
  dv_t              dv_q     [0:QUO_W];
  coef_t            ec;
  logic signed [NUM_W:0] nbv, sv, n1v, n2v;
  dv_t              e_d;
  always_comb begin
    ec  = sq_q[ROOT_W].coef;
    nbv = ec.bn ? $signed((NUM_W+1)'(ec.bm)) : -$signed((NUM_W+1)'(ec.bm));
    sv  = $signed((NUM_W+1)'(sq_q[ROOT_W].root));
    n1v = nbv - sv;
    n2v = nbv + sv;
    e_d      = '0;
    e_d.kind = sq_q[ROOT_W].kind;
    e_d.dvsr = {ec.am, 1'b0};
    case (sq_q[ROOT_W].kind)
      qrs_pkg::KIND_TWO_REAL: begin
        e_d.lane[0].nq  = QUO_W'(abs_num(n1v)) << F;
        e_d.lane[0].neg = n1v[NUM_W] ^ ec.an;
        e_d.lane[1].nq  = QUO_W'(abs_num(n2v)) << F;
        e_d.lane[1].neg = n2v[NUM_W] ^ ec.an;
      end
      qrs_pkg::KIND_DOUBLE: begin
        e_d.lane[0].nq  = QUO_W'(abs_num(nbv)) << F;
        e_d.lane[0].neg = nbv[NUM_W] ^ ec.an;
        e_d.lane[1]     = e_d.lane[0];
      end
      qrs_pkg::KIND_COMPLEX: begin
        e_d.lane[0].nq  = QUO_W'(abs_num(nbv)) << F;
        e_d.lane[0].neg = nbv[NUM_W] ^ ec.an;
        e_d.lane[1]     = e_d.lane[0];
        e_d.lane[2].nq  = QUO_W'(sq_q[ROOT_W].root) << F;
        e_d.lane[2].neg = ec.an;
      end
      qrs_pkg::KIND_LINEAR: begin
        e_d.dvsr        = DIV_W'(ec.bm);
        e_d.lane[0].nq  = QUO_W'(ec.cm) << F;
        e_d.lane[0].neg = ~ec.cn ^ ec.bn;
        e_d.lane[1]     = e_d.lane[0];
      end
      default: begin
        e_d.dvsr = DIV_W'(1);
      end
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= sq_vld_q[ROOT_W];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= e_d;
    end
  end

  // Restoring dividers: one quotient bit per stage in each lane.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    dv_t nxt;
    always_comb begin
      logic [DIV_W:0] rem_sh;
      nxt = dv_q[j];
      for (int l = 0; l < 3; l++) begin
        rem_sh = {dv_q[j].lane[l].rem, dv_q[j].lane[l].nq[QUO_W-1]};
        if (rem_sh >= {1'b0, dv_q[j].dvsr}) begin
          nxt.lane[l].rem = DIV_W'(rem_sh - {1'b0, dv_q[j].dvsr});
          nxt.lane[l].nq  = {dv_q[j].lane[l].nq[QUO_W-2:0], 1'b1};
        end else begin
          nxt.lane[l].rem = rem_sh[DIV_W-1:0];
          nxt.lane[l].nq  = {dv_q[j].lane[l].nq[QUO_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1] <= nxt;
      end
    end
  end

  // Saturation to the output format and the output register.
  logic [W-1:0]       val [3];
  logic [2:0]         sat;
  qrs_pkg::out_beat_t out_d;
  always_comb begin
    logic [QUO_W-1:0] lim;
    logic [W-1:0]     mag;
    for (int l = 0; l < 3; l++) begin
      lim = dv_q[QUO_W].lane[l].neg ? (QUO_W'(1) << (W - 1))
                                    : ((QUO_W'(1) << (W - 1)) - 1'b1);
      sat[l] = dv_q[QUO_W].lane[l].nq > lim;
      mag    = sat[l] ? lim[W-1:0] : dv_q[QUO_W].lane[l].nq[W-1:0];
      val[l] = dv_q[QUO_W].lane[l].neg ? (~mag + 1'b1) : mag;
    end
    out_d.root_kind   = dv_q[QUO_W].kind;
    out_d.first_root  = $signed(val[0]);
    out_d.second_root = $signed(val[1]);
    out_d.imag_part   = $signed(val[2]);
    out_d.overflow    = |sat;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dv_vld_q[QUO_W];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_beat_o <= out_d;
    end
  end

endmodule

`default_nettype wire

### sv/qrs_checker.sv
// Port-level checks of the quadratic root solver, bound to its top level.
`default_nettype none

module qrs_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire qrs_pkg::out_beat_t out_beat_o
);

  // A held result beat stays put until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed while stalled");

  // Input back-pressure only ever comes from a stalled result.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // No root or infinitely many roots carry zero values and no overflow.
  a_zero_cases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.root_kind == qrs_pkg::KIND_NONE ||
                    out_beat_o.root_kind == qrs_pkg::KIND_INFINITE)
    |-> out_beat_o.first_root == '0 && out_beat_o.second_root == '0 &&
        out_beat_o.imag_part == '0 && !out_beat_o.overflow)
    else $error("degenerate case with nonzero result");

  // Only the complex pair has an imaginary part.
  a_imag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.root_kind != qrs_pkg::KIND_COMPLEX
    |-> out_beat_o.imag_part == '0)
    else $error("imaginary part outside complex case");

  // Double, complex and linear cases give equal first and second roots.
  a_same_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.root_kind == qrs_pkg::KIND_DOUBLE ||
                    out_beat_o.root_kind == qrs_pkg::KIND_COMPLEX ||
                    out_beat_o.root_kind == qrs_pkg::KIND_LINEAR)
    |-> out_beat_o.first_root == out_beat_o.second_root)
    else $error("roots differ in a single-valued case");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

`default_nettype wire
